// ===== rtl/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture sample rectangle package
// Shared types and constants: depth codes, register indexes and stage payloads.
// ----------------------------------------------------------------------------
package tsr_pkg;

	localparam logic [1:0] DEPTH_4BPP  = 2'd0;
	localparam logic [1:0] DEPTH_8BPP  = 2'd1;
	localparam logic [1:0] DEPTH_15BPP = 2'd2;
	localparam logic [1:0] DEPTH_RSVD  = 2'd3;

	localparam logic [1:0] REG_MASK_X   = 2'd0;
	localparam logic [1:0] REG_MASK_Y   = 2'd1;
	localparam logic [1:0] REG_OFFSET_X = 2'd2;
	localparam logic [1:0] REG_OFFSET_Y = 2'd3;

	localparam int ADDR_W = 4;

	localparam logic [8:0] PAL_4BPP  = 9'd16;
	localparam logic [8:0] PAL_8BPP  = 9'd256;
	localparam logic [8:0] PAL_15BPP = 9'd0;
	localparam logic [8:0] PAGE_SPAN = 9'd256;

	typedef struct packed {
		logic [4:0] mask_x;
		logic [4:0] mask_y;
		logic [4:0] offset_x;
		logic [4:0] offset_y;
	} cfg_t;

	typedef struct packed {
		logic [7:0] u_low;
		logic [7:0] v_low;
		logic [7:0] u_high;
		logic [7:0] v_high;
		logic [1:0] depth;
		logic [1:0] shift;
		logic [9:0] base_x;
		logic [8:0] base_y;
		logic [8:0] pal;
		logic       win;
		logic       full;
		logic [7:0] free_u;
		logic [7:0] free_v;
		logic [7:0] start_u;
		logic [7:0] start_v;
	} dec_t;

endpackage

// ===== rtl/tsr_if.sv =====
// ----------------------------------------------------------------------------
// Texture sample rectangle channels
// Request channel for primitive bounds and result channel for rectangles.
// ----------------------------------------------------------------------------
interface tsr_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] u_low;
	logic [7:0] v_low;
	logic [7:0] u_high;
	logic [7:0] v_high;
	logic [8:0] page_word;

	modport source (output valid, u_low, v_low, u_high, v_high, page_word, input ready);
	modport sink (input valid, u_low, v_low, u_high, v_high, page_word, output ready);
endinterface

interface tsr_rect_if;
	logic        valid;
	logic        ready;
	logic [10:0] rect_x;
	logic [8:0]  rect_y;
	logic [8:0]  rect_w;
	logic [8:0]  rect_h;
	logic [1:0]  color_depth;
	logic [8:0]  palette_entries;

	modport source (output valid, rect_x, rect_y, rect_w, rect_h, color_depth,
		palette_entries, input ready);
	modport sink (input valid, rect_x, rect_y, rect_w, rect_h, color_depth,
		palette_entries, output ready);
endinterface

// ===== rtl/tsr_cfg.sv =====
// ----------------------------------------------------------------------------
// Texture sample rectangle configuration registers
// APB register file holding the texture window mask and offset.
// ----------------------------------------------------------------------------
module tsr_cfg
	import tsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [4:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_MASK_X:   cfg_q.mask_x   <= pwdata[4:0];
				REG_MASK_Y:   cfg_q.mask_y   <= pwdata[4:0];
				REG_OFFSET_X: cfg_q.offset_x <= pwdata[4:0];
				REG_OFFSET_Y: cfg_q.offset_y <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MASK_X:   rd_val = cfg_q.mask_x;
			REG_MASK_Y:   rd_val = cfg_q.mask_y;
			REG_OFFSET_X: rd_val = cfg_q.offset_x;
			REG_OFFSET_Y: rd_val = cfg_q.offset_y;
		endcase
	end

	assign prdata = {27'd0, rd_val};

endmodule

// ===== rtl/tsr_decode.sv =====
// ----------------------------------------------------------------------------
// Texture sample rectangle decode stage
// First pipeline stage: page word decode, window terms and case flags.
// ----------------------------------------------------------------------------
module tsr_decode
	import tsr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	tsr_item_if.sink item,
	input  cfg_t     cfg,
	input  logic     next_ready,
	output logic     valid_s1,
	output dec_t     dec_s1
);

	logic [1:0] depth;
	logic [1:0] shift;
	logic [8:0] pal;
	logic       s1_en;
	dec_t       dec;

	assign s1_en      = !valid_s1 || next_ready;
	assign item.ready = s1_en;

	always_comb begin
		depth = (item.page_word[8:7] == DEPTH_RSVD) ? DEPTH_15BPP : item.page_word[8:7];
		unique case (depth)
			DEPTH_4BPP: begin
				shift = 2'd2;
				pal   = PAL_4BPP;
			end
			DEPTH_8BPP: begin
				shift = 2'd1;
				pal   = PAL_8BPP;
			end
			default: begin
				shift = 2'd0;
				pal   = PAL_15BPP;
			end
		endcase
	end

	always_comb begin
		dec.u_low   = item.u_low;
		dec.v_low   = item.v_low;
		dec.u_high  = item.u_high;
		dec.v_high  = item.v_high;
		dec.depth   = depth;
		dec.shift   = shift;
		dec.base_x  = {item.page_word[3:0], 6'd0};
		dec.base_y  = {item.page_word[4], 8'd0};
		dec.pal     = pal;
		dec.win     = (cfg.mask_x != 5'd0) || (cfg.mask_y != 5'd0);
		dec.full    = ((item.u_low == 8'd0) && (item.u_high == 8'hFF))
			|| ((item.v_low == 8'd0) && (item.v_high == 8'hFF));
		dec.free_u  = ~{cfg.mask_x, 3'd0};
		dec.free_v  = ~{cfg.mask_y, 3'd0};
		dec.start_u = {cfg.offset_x & cfg.mask_x, 3'd0};
		dec.start_v = {cfg.offset_y & cfg.mask_y, 3'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && item.valid) begin
			dec_s1 <= dec;
		end
	end

endmodule

// ===== rtl/tsr_span.sv =====
// ----------------------------------------------------------------------------
// Texture sample rectangle span stages
// Second stage picks offsets and span operands; third stage subtracts, clamps
// and adds the page base, and holds the result for the downstream side.
// ----------------------------------------------------------------------------
module tsr_span
	import tsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  dec_t       dec_s1,
	output logic       ready_s1,
	tsr_rect_if.source rect
);

	logic       s2_en;
	logic       s3_en;
	logic       valid_s2;
	logic       valid_s3;

	logic [7:0] xoff;
	logic [7:0] yoff;
	logic [8:0] wa;
	logic [7:0] wb;
	logic [8:0] ha;
	logic [7:0] hb;
	logic [7:0] left;
	logic [8:0] right;
	logic [8:0] round_add;

	logic [7:0] xoff_s2;
	logic [7:0] yoff_s2;
	logic [8:0] wa_s2;
	logic [7:0] wb_s2;
	logic [8:0] ha_s2;
	logic [7:0] hb_s2;
	logic [9:0] base_x_s2;
	logic [8:0] base_y_s2;
	logic [1:0] depth_s2;
	logic [8:0] pal_s2;

	logic [9:0] wdiff;
	logic [9:0] hdiff;

	logic [10:0] rect_x_s3;
	logic [8:0]  rect_y_s3;
	logic [8:0]  rect_w_s3;
	logic [8:0]  rect_h_s3;
	logic [1:0]  depth_s3;
	logic [8:0]  pal_s3;

	assign s3_en    = !valid_s3 || rect.ready;
	assign s2_en    = !valid_s2 || s3_en;
	assign ready_s1 = s2_en;

	always_comb begin
		left      = dec_s1.u_low >> dec_s1.shift;
		round_add = (9'd1 << dec_s1.shift) - 9'd1;
		right     = ({1'b0, dec_s1.u_high} + round_add) >> dec_s1.shift;
		priority if (dec_s1.win) begin
			xoff = dec_s1.start_u >> dec_s1.shift;
			yoff = dec_s1.start_v;
			wa   = ({1'b0, dec_s1.free_u} + 9'd1) >> dec_s1.shift;
			wb   = 8'd0;
			ha   = {1'b0, dec_s1.free_v} + 9'd1;
			hb   = 8'd0;
		end else if (dec_s1.full) begin
			xoff = 8'd0;
			yoff = 8'd0;
			wa   = PAGE_SPAN >> dec_s1.shift;
			wb   = 8'd0;
			ha   = PAGE_SPAN;
			hb   = 8'd0;
		end else begin
			xoff = left;
			yoff = dec_s1.v_low;
			wa   = right;
			wb   = left;
			ha   = {1'b0, dec_s1.v_high} + 9'd1;
			hb   = dec_s1.v_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_en) begin
				valid_s2 <= valid_s1;
			end
			if (s3_en) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && valid_s1) begin
			xoff_s2   <= xoff;
			yoff_s2   <= yoff;
			wa_s2     <= wa;
			wb_s2     <= wb;
			ha_s2     <= ha;
			hb_s2     <= hb;
			base_x_s2 <= dec_s1.base_x;
			base_y_s2 <= dec_s1.base_y;
			depth_s2  <= dec_s1.depth;
			pal_s2    <= dec_s1.pal;
		end
	end

	assign wdiff = {1'b0, wa_s2} - {2'b00, wb_s2};
	assign hdiff = {1'b0, ha_s2} - {2'b00, hb_s2};

	always_ff @(posedge clk) begin
		if (s3_en && valid_s2) begin
			rect_x_s3 <= {1'b0, base_x_s2} + {3'd0, xoff_s2};
			rect_y_s3 <= base_y_s2 + {1'b0, yoff_s2};
			rect_w_s3 <= wdiff[9] ? 9'd0 : wdiff[8:0];
			rect_h_s3 <= hdiff[9] ? 9'd0 : hdiff[8:0];
			depth_s3  <= depth_s2;
			pal_s3    <= pal_s2;
		end
	end

	assign rect.valid           = valid_s3;
	assign rect.rect_x          = rect_x_s3;
	assign rect.rect_y          = rect_y_s3;
	assign rect.rect_w          = rect_w_s3;
	assign rect.rect_h          = rect_h_s3;
	assign rect.color_depth     = depth_s3;
	assign rect.palette_entries = pal_s3;

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rect_w_s3 <= PAGE_SPAN) && (rect_h_s3 <= PAGE_SPAN))
		else $error("rectangle extent above one page");

	a_depth_pal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ((depth_s3 == DEPTH_4BPP) && (pal_s3 == PAL_4BPP))
			|| ((depth_s3 == DEPTH_8BPP) && (pal_s3 == PAL_8BPP))
			|| ((depth_s3 == DEPTH_15BPP) && (pal_s3 == PAL_15BPP)))
		else $error("palette size does not match color depth");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !s2_en) |=> valid_s2 && valid_s3)
		else $error("stalled request dropped from stage two");

	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !valid_s3) |=> valid_s3)
		else $error("stage three failed to take a waiting request");

endmodule

// ===== rtl/texture_sample_rect_top.sv =====
// ----------------------------------------------------------------------------
// Texture sample rectangle top level
// VRAM rectangle that one textured primitive may sample.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result side is not
// stalling, and returns its rectangle through three register stages:
// decode of the page word and window terms, selection of offsets and span
// operands, and the final subtract, clamp and base add. The third stage
// holds its result until it is taken, and a stall backs up through the
// stages without losing or repeating a request. Window registers are
// written over APB and should only change while no request is in flight.
module texture_sample_rect_top
	import tsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	tsr_item_if.sink          item,
	tsr_rect_if.source        rect
);

	cfg_t cfg;
	logic valid_s1;
	dec_t dec_s1;
	logic ready_s1;

	tsr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsr_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.next_ready (ready_s1),
		.valid_s1   (valid_s1),
		.dec_s1     (dec_s1)
	);

	tsr_span u_span (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.ready_s1 (ready_s1),
		.rect     (rect)
	);

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Texture sample rectangle testbench
// Sends primitive bounds under a series of texture window settings, with
// random gaps on the request side and random stalls on the result side.
// Every accepted request is predicted on the spot and each rectangle that
// comes out is compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb;
	import tsr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN      = 10;

	typedef struct packed {
		logic [7:0] u_low;
		logic [7:0] v_low;
		logic [7:0] u_high;
		logic [7:0] v_high;
		logic [8:0] page_word;
	} prim_t;

	typedef struct packed {
		logic [10:0] x;
		logic [8:0]  y;
		logic [8:0]  w;
		logic [8:0]  h;
		logic [1:0]  depth;
		logic [8:0]  pal;
	} rect_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	tsr_item_if prim_bus();
	tsr_rect_if rect_bus();

	prim_t pending_prims[$];
	rect_t expected_rects[$];
	cfg_t  window_cfg;
	int    prims_total;
	int    rects_seen;
	int    mismatches;
	int    send_gap;
	int    stall_left;
	int    quiet_cycles;
	bit    calm;

	texture_sample_rect_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (prim_bus),
		.rect    (rect_bus)
	);

	always #6 clk = ~clk;

	function automatic rect_t sample_rect(prim_t p, cfg_t c);
		rect_t      r;
		logic [1:0] depth;
		int         sh, bx, by, lft, rgt, rx, ry, rw, rh;
		depth = (p.page_word[8:7] == DEPTH_RSVD) ? DEPTH_15BPP : p.page_word[8:7];
		case (depth)
			DEPTH_4BPP: sh = 2;
			DEPTH_8BPP: sh = 1;
			default:    sh = 0;
		endcase
		bx = int'(p.page_word[3:0]) * 64;
		by = int'(p.page_word[4]) * 256;
		if (c.mask_x == 5'd0 && c.mask_y == 5'd0) begin
			if ((p.u_low == 8'd0 && p.u_high == 8'hFF) ||
					(p.v_low == 8'd0 && p.v_high == 8'hFF)) begin
				rx = bx;
				ry = by;
				rw = 256 >> sh;
				rh = 256;
			end else begin
				lft = int'(p.u_low) >> sh;
				rgt = (int'(p.u_high) + (1 << sh) - 1) >> sh;
				rx  = bx + lft;
				ry  = by + int'(p.v_low);
				rw  = rgt - lft;
				rh  = int'(p.v_high) - int'(p.v_low) + 1;
			end
		end else begin
			// The free span of an axis is the complement of its mask, plus one.
			rx = bx + ((int'(c.offset_x & c.mask_x) * 8) >> sh);
			ry = by + int'(c.offset_y & c.mask_y) * 8;
			rw = (256 - int'(c.mask_x) * 8) >> sh;
			rh = 256 - int'(c.mask_y) * 8;
		end
		if (rw < 0) rw = 0;
		if (rh < 0) rh = 0;
		r.x     = rx[10:0];
		r.y     = ry[8:0];
		r.w     = rw[8:0];
		r.h     = rh[8:0];
		r.depth = depth;
		r.pal   = (depth == DEPTH_4BPP) ? PAL_4BPP : (depth == DEPTH_8BPP) ? PAL_8BPP : PAL_15BPP;
		return r;
	endfunction

	function automatic prim_t random_prim();
		prim_t      p;
		logic [7:0] a, b;
		int         kind;
		kind        = $urandom_range(0, 15);
		p.page_word = 9'($urandom);
		a           = 8'($urandom);
		b           = 8'($urandom);
		p.u_low     = (a < b) ? a : b;
		p.u_high    = (a < b) ? b : a;
		a           = 8'($urandom);
		b           = 8'($urandom);
		p.v_low     = (a < b) ? a : b;
		p.v_high    = (a < b) ? b : a;
		case (kind)
			0: begin
				p.u_low  = 8'd0;
				p.u_high = 8'hFF;
			end
			1: begin
				p.v_low  = 8'd0;
				p.v_high = 8'hFF;
			end
			2, 3: begin
				p.u_low  = 8'($urandom);
				p.u_high = 8'($urandom);
				p.v_low  = 8'($urandom);
				p.v_high = 8'($urandom);
			end
			4, 5, 6: begin
				p.u_high = p.u_low + 8'($urandom_range(0, 4));
				p.v_high = p.v_low + 8'($urandom_range(0, 2));
			end
			default: ;
		endcase
		return p;
	endfunction

	function automatic void report_mismatch(string what, rect_t want, rect_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("%s: expected x=%0d y=%0d w=%0d h=%0d depth=%0d pal=%0d", what,
				want.x, want.y, want.w, want.h, want.depth, want.pal);
			$display("%s: actual   x=%0d y=%0d w=%0d h=%0d depth=%0d pal=%0d", what,
				got.x, got.y, got.w, got.h, got.depth, got.pal);
		end
	endfunction

	task automatic add_prim(input logic [7:0] ul, input logic [7:0] vl,
			input logic [7:0] uh, input logic [7:0] vh, input logic [8:0] pw);
		prim_t p;
		p.u_low     = ul;
		p.v_low     = vl;
		p.u_high    = uh;
		p.v_high    = vh;
		p.page_word = pw;
		pending_prims = {pending_prims, p};
		prims_total++;
	endtask

	task automatic add_random(input int n);
		repeat (n) begin
			pending_prims = {pending_prims, random_prim()};
			prims_total++;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom & 32'hFFFF_FFE0) | {27'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MASK_X:   window_cfg.mask_x   = val;
			REG_MASK_Y:   window_cfg.mask_y   = val;
			REG_OFFSET_X: window_cfg.offset_x = val;
			REG_OFFSET_Y: window_cfg.offset_y = val;
			default: ;
		endcase
	endtask

	// The window registers change only once every rectangle has come back.
	task automatic set_window(input cfg_t c);
		while (rects_seen != prims_total) @(negedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_MASK_X, c.mask_x);
		write_reg(REG_MASK_Y, c.mask_y);
		write_reg(REG_OFFSET_X, c.offset_x);
		write_reg(REG_OFFSET_Y, c.offset_y);
	endtask

	always @(posedge clk) begin
		prim_t got;
		if (arst_n) begin
			if (prim_bus.valid && prim_bus.ready) begin
				got.u_low     = prim_bus.u_low;
				got.v_low     = prim_bus.v_low;
				got.u_high    = prim_bus.u_high;
				got.v_high    = prim_bus.v_high;
				got.page_word = prim_bus.page_word;
				expected_rects = {expected_rects, sample_rect(got, window_cfg)};
			end
			if (!prim_bus.valid || prim_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					prim_bus.valid <= 1'b0;
				end else if (pending_prims.size() != 0) begin
					got = pending_prims.pop_front();
					prim_bus.valid     <= 1'b1;
					prim_bus.u_low     <= got.u_low;
					prim_bus.v_low     <= got.v_low;
					prim_bus.u_high    <= got.u_high;
					prim_bus.v_high    <= got.v_high;
					prim_bus.page_word <= got.page_word;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 5);
				end else begin
					prim_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		rect_t got;
		rect_t want;
		if (arst_n) begin
			if (rect_bus.valid && rect_bus.ready) begin
				got.x     = rect_bus.rect_x;
				got.y     = rect_bus.rect_y;
				got.w     = rect_bus.rect_w;
				got.h     = rect_bus.rect_h;
				got.depth = rect_bus.color_depth;
				got.pal   = rect_bus.palette_entries;
				if (expected_rects.size() == 0) begin
					report_mismatch("rectangle with no request outstanding", got, got);
				end else begin
					want = expected_rects.pop_front();
					rects_seen++;
					if (got !== want)
						report_mismatch("rectangle mismatch", want, got);
				end
			end
			if (calm) begin
				rect_bus.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rect_bus.ready <= 1'b0;
			end else begin
				rect_bus.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 5);
			end
		end
	end

	always @(posedge clk) begin
		if ((prim_bus.valid && prim_bus.ready) || (rect_bus.valid && rect_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		prim_bus.valid     = 1'b0;
		prim_bus.u_low     = '0;
		prim_bus.v_low     = '0;
		prim_bus.u_high    = '0;
		prim_bus.v_high    = '0;
		prim_bus.page_word = '0;
		rect_bus.ready     = 1'b0;
		window_cfg         = '0;
		prims_total        = 0;
		rects_seen         = 0;
		mismatches         = 0;
		send_gap           = 0;
		stall_left         = 0;
		quiet_cycles       = 0;
		calm               = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// No window: full axes, plain bounds, zero and reversed spans, all depths.
		set_window('0);
		add_prim(8'd0,   8'd0,   8'd255, 8'd255, 9'h000);
		add_prim(8'd0,   8'd5,   8'd255, 8'd9,   9'h08F);
		add_prim(8'd3,   8'd0,   8'd200, 8'd255, 9'h11F);
		add_prim(8'd0,   8'd0,   8'd255, 8'd255, 9'h1FF);
		add_prim(8'd4,   8'd7,   8'd4,   8'd7,   9'h000);
		add_prim(8'd5,   8'd7,   8'd6,   8'd7,   9'h000);
		add_prim(8'd200, 8'd100, 8'd10,  8'd50,  9'h090);
		add_prim(8'd255, 8'd255, 8'd255, 8'd255, 9'h100);
		add_prim(8'd0,   8'd0,   8'd0,   8'd0,   9'h060);
		add_prim(8'd1,   8'd0,   8'd254, 8'd254, 9'h17F);
		add_prim(8'd0,   8'd1,   8'd255, 8'd254, 9'h180);
		add_prim(8'd1,   8'd0,   8'd255, 8'd255, 9'h0EF);
		add_prim(8'd0,   8'd0,   8'd254, 8'd0,   9'h010);
		add_prim(8'd128, 8'd64,  8'd127, 8'd63,  9'h08A);
		add_prim(8'd7,   8'd9,   8'd9,   8'd8,   9'h1E5);
		add_random(300);

		// Widest masks and offsets.
		c = '{mask_x: 5'd31, mask_y: 5'd31, offset_x: 5'd31, offset_y: 5'd31};
		set_window(c);
		add_prim(8'd0,   8'd0,   8'd255, 8'd255, 9'h000);
		add_prim(8'd10,  8'd20,  8'd30,  8'd40,  9'h09F);
		add_prim(8'd255, 8'd255, 8'd0,   8'd0,   9'h110);
		add_prim(8'd1,   8'd2,   8'd3,   8'd4,   9'h18F);
		add_random(120);

		c = '{mask_x: 5'd0, mask_y: 5'd1, offset_x: 5'd31, offset_y: 5'd31};
		set_window(c);
		add_random(120);

		c = '{mask_x: 5'd16, mask_y: 5'd0, offset_x: 5'd31, offset_y: 5'd0};
		set_window(c);
		add_random(120);

		repeat (4) begin
			c.mask_x   = 5'($urandom);
			c.mask_y   = 5'($urandom);
			c.offset_x = 5'($urandom);
			c.offset_y = 5'($urandom);
			set_window(c);
			add_random(90);
		end

		// Offsets alone do not open a window; this last stretch runs without idling.
		c = '{mask_x: 5'd0, mask_y: 5'd0, offset_x: 5'd31, offset_y: 5'd31};
		set_window(c);
		calm = 1'b1;
		add_random(200);

		while (rects_seen != prims_total) @(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_rects.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
